>>> hdl/huffman_tree_walk_decoder_core_defines.svh
// assertion macros for the huffman tree walk decoder checker
// no dependencies; taken in by the checker file only
`ifndef HUFFMAN_TREE_WALK_DECODER_CORE_DEFINES_SVH
`define HUFFMAN_TREE_WALK_DECODER_CORE_DEFINES_SVH

// consequent must hold in the same cycle as the antecedent
`define HTWD_ASSERT_SAME(name, clk, rstn, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("htwd: same-cycle check failed");

// consequent must hold in the cycle after the antecedent
`define HTWD_ASSERT_NEXT(name, clk, rstn, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("htwd: next-cycle check failed");

`endif

>>> hdl/htwd_pkg.sv
// shared types and constants for the huffman tree walk decoder
// no dependencies
`timescale 1ns / 1ps

package htwd_pkg;

  // fixed field widths
  localparam int unsigned IDX_W     = 9;
  localparam int unsigned CNT_W     = 24;
  localparam int unsigned BYTE_W    = 8;
  localparam int unsigned SYM_W     = 8;
  localparam int unsigned CMD_W     = 2;
  localparam int unsigned CFG_IDX_W = 2;
  localparam int unsigned BCNT_W    = $clog2(BYTE_W + 1);

  // node entry layout, symbol sits above the flags
  localparam int unsigned LEFT_LSB  = 0;
  localparam int unsigned RIGHT_LSB = IDX_W;
  localparam int unsigned LP_POS    = 2 * IDX_W;
  localparam int unsigned RP_POS    = 2 * IDX_W + 1;
  localparam int unsigned LEAF_POS  = 2 * IDX_W + 2;
  localparam int unsigned SYM_LSB   = 2 * IDX_W + 3;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_ROOT  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_COUNT = 2'd1;

  // item commands
  typedef enum logic [CMD_W-1:0] {
    CMD_LOAD  = 2'd0,
    CMD_START = 2'd1,
    CMD_CODE  = 2'd2
  } cmd_e;

endpackage

>>> hdl/htwd_node_ram.sv
// node table storage: one write port, one read port with registered data
// no dependencies
`timescale 1ns / 1ps

module htwd_node_ram #(
  parameter int unsigned DEPTH = 512,
  parameter int unsigned DW    = 29,
  parameter int unsigned AW    = $clog2(DEPTH)
) (
  input  logic          clk_i,
  input  logic          we_i,
  input  logic [AW-1:0] waddr_i,
  input  logic [DW-1:0] wdata_i,
  input  logic [AW-1:0] raddr_i,
  output logic [DW-1:0] rdata_o
);

  logic [DW-1:0] mem_q [DEPTH];
  logic [DW-1:0] rdata_q;

  // write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // registered read port
  always_ff @(posedge clk_i) begin
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

>>> hdl/huffman_tree_walk_decoder_core.sv
// huffman tree walk decoder top level: item handshake, walk sequencer, result staging
// depends on htwd_pkg and htwd_node_ram
`timescale 1ns / 1ps
//
// Usage
//   Input channel (in_valid_i / in_stall_o) carries one command per beat:
//   load node writes one node table entry, start message puts the walk at
//   the root and loads the symbol counter, code byte feeds eight code bits
//   MSB first. Configuration (cfg_valid_i / cfg_ready_o) sets the root index
//   (index 0) and the symbol count (index 1); write it only while idle.
//   Output channel (out_valid_o / out_stall_i) gives symbol, walk_error,
//   message_done and last; last marks the final result of a code byte.
// Timing
//   A code byte takes a step per consumed bit, a step per decoded symbol
//   (root re-read), a further step when the final bit ends on an interior node
//   and a step to close the beat; an error or the final symbol stops it early,
//   and output stalls lengthen it. No new item is taken until the beat closes.
//   Each result is held in a staging slot until the next result or the close
//   of the beat moves it on. The bound is the single read port of the node
//   table, since each step needs the entry fetched by the step before.
// Reset and stall
//   Reset clears the walk (idle, node 0, count 0) and both registers; the node
//   table content is undefined until loaded. A stalled output holds its beat;
//   the walk carries on until a second result needs the staging slot, then waits.

module huffman_tree_walk_decoder_core
  import htwd_pkg::*;
#(
  parameter int unsigned NODE_COUNT  = 512,
  parameter int unsigned SYMBOL_BITS = 8
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  // configuration
  input  logic                 cfg_valid_i,
  output logic                 cfg_ready_o,
  input  logic [CFG_IDX_W-1:0] cfg_index_i,
  input  logic [CNT_W-1:0]     cfg_data_i,
  // input items
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  logic [CMD_W-1:0]     cmd_i,
  input  logic [IDX_W-1:0]     node_index_i,
  input  logic [IDX_W-1:0]     left_child_i,
  input  logic [IDX_W-1:0]     right_child_i,
  input  logic                 left_present_i,
  input  logic                 right_present_i,
  input  logic                 leaf_flag_i,
  input  logic [SYM_W-1:0]     leaf_symbol_i,
  input  logic [BYTE_W-1:0]    code_byte_i,
  // results
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output logic [SYM_W-1:0]     symbol_o,
  output logic                 walk_error_o,
  output logic                 message_done_o,
  output logic                 last_o
);

  localparam int unsigned AW      = $clog2(NODE_COUNT);
  localparam int unsigned ENTRY_W = SYM_LSB + SYMBOL_BITS;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_WALK,
    ST_FLUSH
  } state_e;

  state_e              state_q, state_d;
  logic [IDX_W-1:0]    root_q, root_d;
  logic [CNT_W-1:0]    count_q, count_d;
  logic [IDX_W-1:0]    cur_q, cur_d;
  logic [CNT_W-1:0]    left_q, left_d;
  logic                active_q, active_d;
  logic [BYTE_W-1:0]   shift_q, shift_d;
  logic [BCNT_W-1:0]   bits_q, bits_d;
  logic                stepped_q, stepped_d;
  logic                pend_valid_q, pend_valid_d;
  logic [SYM_W-1:0]    pend_sym_q, pend_sym_d;
  logic                pend_err_q, pend_err_d;
  logic                pend_done_q, pend_done_d;
  logic                out_valid_q, out_valid_d;
  logic [SYM_W-1:0]    out_sym_q, out_sym_d;
  logic                out_err_q, out_err_d;
  logic                out_done_q, out_done_d;
  logic                out_last_q, out_last_d;

  logic                ram_we;
  logic [AW-1:0]       ram_raddr;
  logic [ENTRY_W-1:0]  ram_wdata;
  logic [ENTRY_W-1:0]  ram_rdata;

  logic [ENTRY_W-1:0]  ent;
  logic                cur_oor;
  logic                bit_v;
  logic                present;
  logic [IDX_W-1:0]    child;
  logic                child_ok;
  logic                is_leaf;
  logic [SYM_W-1:0]    leaf_sym;
  logic                out_free;
  logic                can_push;
  logic                res_req;
  logic [SYM_W-1:0]    res_sym;
  logic                res_err;
  logic                res_done;

  // node table
  assign ram_wdata = {SYMBOL_BITS'(leaf_symbol_i), leaf_flag_i, right_present_i,
                      left_present_i, right_child_i, left_child_i};

  htwd_node_ram #(
    .DEPTH (NODE_COUNT),
    .DW    (ENTRY_W),
    .AW    (AW)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (AW'(node_index_i)),
    .wdata_i (ram_wdata),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  // decode of the entry for the current node, out of range reads as empty
  assign cur_oor  = !(32'(cur_q) < NODE_COUNT);
  assign ent      = cur_oor ? '0 : ram_rdata;
  assign bit_v    = shift_q[BYTE_W-1];
  assign present  = bit_v ? ent[RP_POS] : ent[LP_POS];
  assign child    = bit_v ? ent[RIGHT_LSB +: IDX_W] : ent[LEFT_LSB +: IDX_W];
  assign child_ok = present && (32'(child) < NODE_COUNT);
  assign is_leaf  = ent[LEAF_POS];
  assign leaf_sym = SYM_W'(ent[SYM_LSB +: SYMBOL_BITS]);

  // result staging: one pending slot ahead of the output register
  assign out_free = !out_valid_q || !out_stall_i;
  assign can_push = !pend_valid_q || out_free;

  // walk sequencer
  always_comb begin
    state_d      = state_q;
    root_d       = root_q;
    count_d      = count_q;
    cur_d        = cur_q;
    left_d       = left_q;
    active_d     = active_q;
    shift_d      = shift_q;
    bits_d       = bits_q;
    stepped_d    = stepped_q;
    ram_we       = 1'b0;
    ram_raddr    = AW'(cur_q);
    res_req      = 1'b0;
    res_sym      = '0;
    res_err      = 1'b0;
    res_done     = 1'b0;

    // configuration writes
    if (cfg_valid_i) begin
      case (cfg_index_i)
        CFG_ROOT:  root_d  = cfg_data_i[IDX_W-1:0];
        CFG_COUNT: count_d = cfg_data_i;
        default: ;
      endcase
    end

    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          unique case (cmd_e'(cmd_i))
            CMD_LOAD: begin
              ram_we = 32'(node_index_i) < NODE_COUNT;
            end
            CMD_START: begin
              cur_d    = root_q;
              left_d   = count_q;
              active_d = (count_q != '0);
            end
            CMD_CODE: begin
              if (active_q) begin
                shift_d   = code_byte_i;
                bits_d    = BCNT_W'(BYTE_W);
                stepped_d = 1'b0;
                state_d   = ST_WALK;
              end
            end
            default: ;
          endcase
        end
      end
      ST_WALK: begin
        if (stepped_q && is_leaf) begin
          // landed on a leaf: emit and go back to the root
          if (can_push) begin
            res_req   = 1'b1;
            res_sym   = leaf_sym;
            res_done  = (left_q == CNT_W'(1));
            left_d    = left_q - 1'b1;
            cur_d     = root_q;
            ram_raddr = AW'(root_q);
            stepped_d = 1'b0;
            if (left_q == CNT_W'(1)) begin
              active_d = 1'b0;
              state_d  = ST_FLUSH;
            end else if (bits_q == '0) begin
              state_d = ST_FLUSH;
            end
          end
        end else if (bits_q == '0) begin
          state_d = ST_FLUSH;
        end else if (!child_ok) begin
          // missing child halts the walk until the next start
          if (can_push) begin
            res_req  = 1'b1;
            res_err  = 1'b1;
            active_d = 1'b0;
            state_d  = ST_FLUSH;
          end
        end else begin
          cur_d     = child;
          ram_raddr = AW'(child);
          shift_d   = {shift_q[BYTE_W-2:0], 1'b0};
          bits_d    = bits_q - 1'b1;
          stepped_d = 1'b1;
        end
      end
      ST_FLUSH: begin
        if (!pend_valid_q || out_free) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // staging of results into the output register
  always_comb begin
    pend_valid_d = pend_valid_q;
    pend_sym_d   = pend_sym_q;
    pend_err_d   = pend_err_q;
    pend_done_d  = pend_done_q;
    out_valid_d  = out_valid_q && out_stall_i;
    out_sym_d    = out_sym_q;
    out_err_d    = out_err_q;
    out_done_d   = out_done_q;
    out_last_d   = out_last_q;

    if (res_req) begin
      if (pend_valid_q) begin
        out_valid_d = 1'b1;
        out_sym_d   = pend_sym_q;
        out_err_d   = pend_err_q;
        out_done_d  = pend_done_q;
        out_last_d  = 1'b0;
      end
      pend_valid_d = 1'b1;
      pend_sym_d   = res_sym;
      pend_err_d   = res_err;
      pend_done_d  = res_done;
    end else if (state_q == ST_FLUSH && pend_valid_q && out_free) begin
      out_valid_d  = 1'b1;
      out_sym_d    = pend_sym_q;
      out_err_d    = pend_err_q;
      out_done_d   = pend_done_q;
      out_last_d   = 1'b1;
      pend_valid_d = 1'b0;
    end
  end

  // state and registered outputs
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_IDLE;
      root_q       <= '0;
      count_q      <= '0;
      cur_q        <= '0;
      left_q       <= '0;
      active_q     <= 1'b0;
      shift_q      <= '0;
      bits_q       <= '0;
      stepped_q    <= 1'b0;
      pend_valid_q <= 1'b0;
      pend_sym_q   <= '0;
      pend_err_q   <= 1'b0;
      pend_done_q  <= 1'b0;
      out_valid_q  <= 1'b0;
      out_sym_q    <= '0;
      out_err_q    <= 1'b0;
      out_done_q   <= 1'b0;
      out_last_q   <= 1'b0;
    end else begin
      state_q      <= state_d;
      root_q       <= root_d;
      count_q      <= count_d;
      cur_q        <= cur_d;
      left_q       <= left_d;
      active_q     <= active_d;
      shift_q      <= shift_d;
      bits_q       <= bits_d;
      stepped_q    <= stepped_d;
      pend_valid_q <= pend_valid_d;
      pend_sym_q   <= pend_sym_d;
      pend_err_q   <= pend_err_d;
      pend_done_q  <= pend_done_d;
      out_valid_q  <= out_valid_d;
      out_sym_q    <= out_sym_d;
      out_err_q    <= out_err_d;
      out_done_q   <= out_done_d;
      out_last_q   <= out_last_d;
    end
  end

  // ports
  assign cfg_ready_o    = 1'b1;
  assign in_stall_o     = (state_q != ST_IDLE);
  assign out_valid_o    = out_valid_q;
  assign symbol_o       = out_sym_q;
  assign walk_error_o   = out_err_q;
  assign message_done_o = out_done_q;
  assign last_o         = out_last_q;

endmodule

>>> hdl/htwd_checker.sv
// port-level checks for the huffman tree walk decoder, bound to the top level
// depends on htwd_pkg and huffman_tree_walk_decoder_core_defines.svh
`timescale 1ns / 1ps
`include "huffman_tree_walk_decoder_core_defines.svh"

module htwd_checker
  import htwd_pkg::*;
(
  input logic             clk_i,
  input logic             rst_ni,
  input logic             in_stall_o,
  input logic             out_valid_o,
  input logic             out_stall_i,
  input logic [SYM_W-1:0] symbol_o,
  input logic             walk_error_o,
  input logic             message_done_o,
  input logic             last_o
);

  // a stalled result beat holds
  `HTWD_ASSERT_NEXT(a_out_hold, clk_i, rst_ni, out_valid_o && out_stall_i, out_valid_o && $stable(symbol_o) && $stable(walk_error_o) && $stable(message_done_o) && $stable(last_o))

  // error results carry a zero symbol and never finish a message
  `HTWD_ASSERT_SAME(a_err_clean, clk_i, rst_ni, out_valid_o && walk_error_o, symbol_o == '0 && !message_done_o)

  // the final symbol of a message ends the code byte
  `HTWD_ASSERT_SAME(a_done_last, clk_i, rst_ni, out_valid_o && message_done_o, last_o)

  // a beat that is not the last one means the byte is still being walked
  `HTWD_ASSERT_SAME(a_busy_mid, clk_i, rst_ni, out_valid_o && !last_o, in_stall_o)

endmodule

bind huffman_tree_walk_decoder_core htwd_checker u_htwd_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .in_stall_o     (in_stall_o),
  .out_valid_o    (out_valid_o),
  .out_stall_i    (out_stall_i),
  .symbol_o       (symbol_o),
  .walk_error_o   (walk_error_o),
  .message_done_o (message_done_o),
  .last_o         (last_o)
);
